[src/jssp_pkg.sv]
// Shared types and constants for the JSON subset stream parser.
// No dependencies; used by every module in src.
`default_nettype none

package jssp_pkg;

    // Parser modes
    typedef enum logic [3:0] {
        M_TOP,
        M_OBJ_FIRST,
        M_OBJ_KEY,
        M_COLON,
        M_VALUE,
        M_OBJ_NEXT,
        M_ARR_FIRST,
        M_ARR_ENTRY,
        M_ARR_NEXT,
        M_STR,
        M_ESC,
        M_HEX,
        M_TAIL,
        M_ERR
    } t_mode;

    // Result events
    typedef enum logic [2:0] {
        EV_BYTE,
        EV_STR_END,
        EV_OBJ_OPEN,
        EV_OBJ_CLOSE,
        EV_ARR_OPEN,
        EV_ARR_CLOSE,
        EV_ERROR,
        EV_DONE
    } t_event;

    // String roles
    localparam logic [1:0] ROLE_KEY   = 2'd0;
    localparam logic [1:0] ROLE_VALUE = 2'd1;
    localparam logic [1:0] ROLE_ENTRY = 2'd2;

    // Error codes
    localparam logic [3:0] ERR_NONE       = 4'd0;
    localparam logic [3:0] ERR_BRACE      = 4'd1;
    localparam logic [3:0] ERR_QUOTE      = 4'd2;
    localparam logic [3:0] ERR_COLON      = 4'd3;
    localparam logic [3:0] ERR_COMMA_BRC  = 4'd4;
    localparam logic [3:0] ERR_COMMA_BRK  = 4'd5;
    localparam logic [3:0] ERR_SYNTAX     = 4'd6;
    localparam logic [3:0] ERR_UNTERM     = 4'd7;
    localparam logic [3:0] ERR_HEX        = 4'd8;
    localparam logic [3:0] ERR_ESCAPE     = 4'd9;
    localparam logic [3:0] ERR_EOF        = 4'd10;
    localparam logic [3:0] ERR_EXTRA      = 4'd11;
    localparam logic [3:0] ERR_DEPTH      = 4'd12;

    // Characters
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;

    // Most results one request can cause
    localparam int MAX_RES = 4;

    // Bundle queue depth between front and back
    localparam int Q_DEPTH = 4;

    typedef struct packed {
        t_event     ev;
        logic [1:0] role;
        logic [7:0] data;
        logic [4:0] depth;
        logic [3:0] code;
    } t_result;

    // All results of one request; cnt is 1..MAX_RES when queued
    typedef struct packed {
        logic [2:0]                 cnt;
        t_result [MAX_RES-1:0]      res;
    } t_bundle;

endpackage

`default_nettype wire

[src/jssp_front.sv]
// Front end: accepts text bytes, runs the parse state machine and builds
// the bundle of results per byte. Depends on jssp_pkg.
`default_nettype none

module jssp_front #(
    parameter int MAX_DEPTH = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_fire,
    input  wire logic [7:0]       i_byte,
    input  wire logic             i_last,
    output jssp_pkg::t_bundle     o_bundle,
    output logic                  o_push
);

    localparam int DW = $clog2(MAX_DEPTH + 1) < 1 ? 1 : $clog2(MAX_DEPTH + 1);

    jssp_pkg::t_mode r_mode, n_mode;
    logic [DW-1:0]   r_depth, n_depth;
    logic [1:0]      r_role, n_role;
    logic [1:0]      r_hex, n_hex;
    logic [15:0]     r_rune, n_rune;

    jssp_pkg::t_bundle bnd;
    logic              ws;
    logic              hex_ok;
    logic [3:0]        digit;

    function automatic logic [4:0] dep5(input logic [DW-1:0] d);
        logic [DW+4:0] ext;
        ext = {5'd0, d};
        return ext[4:0];
    endfunction

    function automatic jssp_pkg::t_result mk(input jssp_pkg::t_event ev,
                                             input logic [1:0] role,
                                             input logic [7:0] data,
                                             input logic [DW-1:0] d,
                                             input logic [3:0] code);
        jssp_pkg::t_result r;
        r.ev    = ev;
        r.role  = role;
        r.data  = data;
        r.depth = dep5(d);
        r.code  = code;
        return r;
    endfunction

    function automatic jssp_pkg::t_bundle push(input jssp_pkg::t_bundle b,
                                               input jssp_pkg::t_result r);
        jssp_pkg::t_bundle nb;
        nb = b;
        nb.res[b.cnt[1:0]] = r;
        nb.cnt = b.cnt + 3'd1;
        return nb;
    endfunction

    always_comb begin
        n_mode  = r_mode;
        n_depth = r_depth;
        n_role  = r_role;
        n_hex   = r_hex;
        n_rune  = r_rune;
        bnd     = '0;

        ws = (i_byte == jssp_pkg::CH_SPACE) || (i_byte == jssp_pkg::CH_TAB) ||
             (i_byte == jssp_pkg::CH_LF) || (i_byte == jssp_pkg::CH_CR);

        hex_ok = 1'b1;
        digit  = 4'd0;
        if (i_byte >= 8'h30 && i_byte <= 8'h39) begin
            digit = i_byte[3:0];
        end else if ((i_byte >= 8'h41 && i_byte <= 8'h46) ||
                     (i_byte >= 8'h61 && i_byte <= 8'h66)) begin
            digit = i_byte[3:0] + 4'd9;
        end else begin
            hex_ok = 1'b0;
        end

        case (r_mode)
            jssp_pkg::M_TOP: begin
                if (!ws) begin
                    if (i_byte == jssp_pkg::CH_LBRACE) begin
                        n_depth = DW'(1);
                        n_mode  = jssp_pkg::M_OBJ_FIRST;
                        bnd = push(bnd, mk(jssp_pkg::EV_OBJ_OPEN, jssp_pkg::ROLE_KEY,
                                           8'd0, n_depth, jssp_pkg::ERR_NONE));
                    end else begin
                        n_mode = jssp_pkg::M_ERR;
                        bnd = push(bnd, mk(jssp_pkg::EV_ERROR, jssp_pkg::ROLE_KEY,
                                           8'd0, r_depth, jssp_pkg::ERR_BRACE));
                    end
                end
            end
            jssp_pkg::M_OBJ_FIRST, jssp_pkg::M_OBJ_NEXT: begin
                if (!ws) begin
                    if (i_byte == jssp_pkg::CH_RBRACE) begin
                        if (r_depth != '0) begin
                            n_depth = r_depth - DW'(1);
                        end
                        bnd = push(bnd, mk(jssp_pkg::EV_OBJ_CLOSE, jssp_pkg::ROLE_KEY,
                                           8'd0, n_depth, jssp_pkg::ERR_NONE));
                        n_mode = (n_depth == '0) ? jssp_pkg::M_TAIL : jssp_pkg::M_OBJ_NEXT;
                    end else if (r_mode == jssp_pkg::M_OBJ_FIRST &&
                                 i_byte == jssp_pkg::CH_QUOTE) begin
                        n_role = jssp_pkg::ROLE_KEY;
                        n_mode = jssp_pkg::M_STR;
                    end else if (r_mode == jssp_pkg::M_OBJ_NEXT &&
                                 i_byte == jssp_pkg::CH_COMMA) begin
                        n_mode = jssp_pkg::M_OBJ_KEY;
                    end else begin
                        n_mode = jssp_pkg::M_ERR;
                        bnd = push(bnd, mk(jssp_pkg::EV_ERROR, jssp_pkg::ROLE_KEY, 8'd0,
                                           r_depth,
                                           (r_mode == jssp_pkg::M_OBJ_FIRST) ?
                                           jssp_pkg::ERR_QUOTE : jssp_pkg::ERR_COMMA_BRC));
                    end
                end
            end
            jssp_pkg::M_OBJ_KEY, jssp_pkg::M_ARR_ENTRY: begin
                if (!ws) begin
                    if (i_byte == jssp_pkg::CH_QUOTE) begin
                        n_role = (r_mode == jssp_pkg::M_OBJ_KEY) ?
                                 jssp_pkg::ROLE_KEY : jssp_pkg::ROLE_ENTRY;
                        n_mode = jssp_pkg::M_STR;
                    end else begin
                        n_mode = jssp_pkg::M_ERR;
                        bnd = push(bnd, mk(jssp_pkg::EV_ERROR, jssp_pkg::ROLE_KEY,
                                           8'd0, r_depth, jssp_pkg::ERR_QUOTE));
                    end
                end
            end
            jssp_pkg::M_COLON: begin
                if (!ws) begin
                    if (i_byte == jssp_pkg::CH_COLON) begin
                        n_mode = jssp_pkg::M_VALUE;
                    end else begin
                        n_mode = jssp_pkg::M_ERR;
                        bnd = push(bnd, mk(jssp_pkg::EV_ERROR, jssp_pkg::ROLE_KEY,
                                           8'd0, r_depth, jssp_pkg::ERR_COLON));
                    end
                end
            end
            jssp_pkg::M_VALUE: begin
                if (!ws) begin
                    if (i_byte == jssp_pkg::CH_QUOTE) begin
                        n_role = jssp_pkg::ROLE_VALUE;
                        n_mode = jssp_pkg::M_STR;
                    end else if (i_byte == jssp_pkg::CH_LBRACE) begin
                        if (r_depth >= DW'(MAX_DEPTH)) begin
                            n_mode = jssp_pkg::M_ERR;
                            bnd = push(bnd, mk(jssp_pkg::EV_ERROR, jssp_pkg::ROLE_KEY,
                                               8'd0, r_depth, jssp_pkg::ERR_DEPTH));
                        end else begin
                            n_depth = r_depth + DW'(1);
                            n_mode  = jssp_pkg::M_OBJ_FIRST;
                            bnd = push(bnd, mk(jssp_pkg::EV_OBJ_OPEN, jssp_pkg::ROLE_KEY,
                                               8'd0, n_depth, jssp_pkg::ERR_NONE));
                        end
                    end else if (i_byte == jssp_pkg::CH_LBRACK) begin
                        n_mode = jssp_pkg::M_ARR_FIRST;
                        bnd = push(bnd, mk(jssp_pkg::EV_ARR_OPEN, jssp_pkg::ROLE_KEY,
                                           8'd0, r_depth, jssp_pkg::ERR_NONE));
                    end else begin
                        n_mode = jssp_pkg::M_ERR;
                        bnd = push(bnd, mk(jssp_pkg::EV_ERROR, jssp_pkg::ROLE_KEY,
                                           8'd0, r_depth, jssp_pkg::ERR_SYNTAX));
                    end
                end
            end
            jssp_pkg::M_ARR_FIRST, jssp_pkg::M_ARR_NEXT: begin
                if (!ws) begin
                    if (i_byte == jssp_pkg::CH_RBRACK) begin
                        n_mode = jssp_pkg::M_OBJ_NEXT;
                        bnd = push(bnd, mk(jssp_pkg::EV_ARR_CLOSE, jssp_pkg::ROLE_KEY,
                                           8'd0, r_depth, jssp_pkg::ERR_NONE));
                    end else if (r_mode == jssp_pkg::M_ARR_FIRST &&
                                 i_byte == jssp_pkg::CH_QUOTE) begin
                        n_role = jssp_pkg::ROLE_ENTRY;
                        n_mode = jssp_pkg::M_STR;
                    end else if (r_mode == jssp_pkg::M_ARR_NEXT &&
                                 i_byte == jssp_pkg::CH_COMMA) begin
                        n_mode = jssp_pkg::M_ARR_ENTRY;
                    end else begin
                        n_mode = jssp_pkg::M_ERR;
                        bnd = push(bnd, mk(jssp_pkg::EV_ERROR, jssp_pkg::ROLE_KEY, 8'd0,
                                           r_depth,
                                           (r_mode == jssp_pkg::M_ARR_FIRST) ?
                                           jssp_pkg::ERR_QUOTE : jssp_pkg::ERR_COMMA_BRK));
                    end
                end
            end
            jssp_pkg::M_STR: begin
                if (i_byte == jssp_pkg::CH_QUOTE) begin
                    bnd = push(bnd, mk(jssp_pkg::EV_STR_END, r_role, 8'd0, r_depth,
                                       jssp_pkg::ERR_NONE));
                    if (r_role == jssp_pkg::ROLE_KEY) begin
                        n_mode = jssp_pkg::M_COLON;
                    end else if (r_role == jssp_pkg::ROLE_VALUE) begin
                        n_mode = jssp_pkg::M_OBJ_NEXT;
                    end else begin
                        n_mode = jssp_pkg::M_ARR_NEXT;
                    end
                end else if (i_byte == jssp_pkg::CH_BSLASH) begin
                    n_mode = jssp_pkg::M_ESC;
                end else begin
                    bnd = push(bnd, mk(jssp_pkg::EV_BYTE, r_role, i_byte, r_depth,
                                       jssp_pkg::ERR_NONE));
                end
            end
            jssp_pkg::M_ESC: begin
                n_mode = jssp_pkg::M_STR;
                case (i_byte)
                    jssp_pkg::CH_QUOTE, jssp_pkg::CH_BSLASH, jssp_pkg::CH_SLASH: begin
                        bnd = push(bnd, mk(jssp_pkg::EV_BYTE, r_role, i_byte, r_depth,
                                           jssp_pkg::ERR_NONE));
                    end
                    jssp_pkg::CH_B: begin
                        bnd = push(bnd, mk(jssp_pkg::EV_BYTE, r_role, 8'd8, r_depth,
                                           jssp_pkg::ERR_NONE));
                    end
                    jssp_pkg::CH_F: begin
                        bnd = push(bnd, mk(jssp_pkg::EV_BYTE, r_role, 8'd12, r_depth,
                                           jssp_pkg::ERR_NONE));
                    end
                    jssp_pkg::CH_N: begin
                        bnd = push(bnd, mk(jssp_pkg::EV_BYTE, r_role, 8'd10, r_depth,
                                           jssp_pkg::ERR_NONE));
                    end
                    jssp_pkg::CH_R: begin
                        bnd = push(bnd, mk(jssp_pkg::EV_BYTE, r_role, 8'd13, r_depth,
                                           jssp_pkg::ERR_NONE));
                    end
                    jssp_pkg::CH_T: begin
                        bnd = push(bnd, mk(jssp_pkg::EV_BYTE, r_role, 8'd9, r_depth,
                                           jssp_pkg::ERR_NONE));
                    end
                    jssp_pkg::CH_U: begin
                        n_mode = jssp_pkg::M_HEX;
                        n_hex  = 2'd0;
                        n_rune = 16'd0;
                    end
                    default: begin
                        n_mode = jssp_pkg::M_ERR;
                        bnd = push(bnd, mk(jssp_pkg::EV_ERROR, jssp_pkg::ROLE_KEY,
                                           8'd0, r_depth, jssp_pkg::ERR_ESCAPE));
                    end
                endcase
            end
            jssp_pkg::M_HEX: begin
                if (!hex_ok) begin
                    n_mode = jssp_pkg::M_ERR;
                    bnd = push(bnd, mk(jssp_pkg::EV_ERROR, jssp_pkg::ROLE_KEY,
                                       8'd0, r_depth, jssp_pkg::ERR_HEX));
                end else begin
                    n_rune = {r_rune[11:0], digit};
                    n_hex  = r_hex + 2'd1;
                    if (r_hex == 2'd3) begin
                        // fourth digit: encode as UTF-8
                        n_mode = jssp_pkg::M_STR;
                        if (n_rune[15:7] == '0) begin
                            bnd = push(bnd, mk(jssp_pkg::EV_BYTE, r_role,
                                               {1'b0, n_rune[6:0]}, r_depth,
                                               jssp_pkg::ERR_NONE));
                        end else if (n_rune[15:11] == '0) begin
                            bnd = push(bnd, mk(jssp_pkg::EV_BYTE, r_role,
                                               {3'b110, n_rune[10:6]}, r_depth,
                                               jssp_pkg::ERR_NONE));
                            bnd = push(bnd, mk(jssp_pkg::EV_BYTE, r_role,
                                               {2'b10, n_rune[5:0]}, r_depth,
                                               jssp_pkg::ERR_NONE));
                        end else begin
                            bnd = push(bnd, mk(jssp_pkg::EV_BYTE, r_role,
                                               {4'b1110, n_rune[15:12]}, r_depth,
                                               jssp_pkg::ERR_NONE));
                            bnd = push(bnd, mk(jssp_pkg::EV_BYTE, r_role,
                                               {2'b10, n_rune[11:6]}, r_depth,
                                               jssp_pkg::ERR_NONE));
                            bnd = push(bnd, mk(jssp_pkg::EV_BYTE, r_role,
                                               {2'b10, n_rune[5:0]}, r_depth,
                                               jssp_pkg::ERR_NONE));
                        end
                    end
                end
            end
            jssp_pkg::M_TAIL: begin
                if (!ws) begin
                    n_mode = jssp_pkg::M_ERR;
                    bnd = push(bnd, mk(jssp_pkg::EV_ERROR, jssp_pkg::ROLE_KEY,
                                       8'd0, r_depth, jssp_pkg::ERR_EXTRA));
                end
            end
            jssp_pkg::M_ERR: begin
                // swallow bytes until the last one
            end
            default: begin
                n_mode = jssp_pkg::M_ERR;
                bnd = push(bnd, mk(jssp_pkg::EV_ERROR, jssp_pkg::ROLE_KEY,
                                   8'd0, r_depth, jssp_pkg::ERR_SYNTAX));
            end
        endcase

        if (i_last) begin
            if (n_mode == jssp_pkg::M_TAIL) begin
                bnd = push(bnd, mk(jssp_pkg::EV_DONE, jssp_pkg::ROLE_KEY,
                                   8'd0, n_depth, jssp_pkg::ERR_NONE));
            end else if (n_mode == jssp_pkg::M_STR || n_mode == jssp_pkg::M_ESC ||
                         n_mode == jssp_pkg::M_HEX) begin
                bnd = push(bnd, mk(jssp_pkg::EV_ERROR, jssp_pkg::ROLE_KEY,
                                   8'd0, n_depth, jssp_pkg::ERR_UNTERM));
            end else if (n_mode != jssp_pkg::M_ERR) begin
                bnd = push(bnd, mk(jssp_pkg::EV_ERROR, jssp_pkg::ROLE_KEY,
                                   8'd0, n_depth, jssp_pkg::ERR_EOF));
            end
            n_mode  = jssp_pkg::M_TOP;
            n_depth = '0;
            n_role  = 2'd0;
            n_hex   = 2'd0;
            n_rune  = 16'd0;
        end
    end

    assign o_bundle = bnd;
    assign o_push   = i_fire && (bnd.cnt != 3'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= jssp_pkg::M_TOP;
            r_depth <= '0;
            r_role  <= 2'd0;
            r_hex   <= 2'd0;
            r_rune  <= 16'd0;
        end else if (i_fire) begin
            r_mode  <= n_mode;
            r_depth <= n_depth;
            r_role  <= n_role;
            r_hex   <= n_hex;
            r_rune  <= n_rune;
        end
    end

endmodule

`default_nettype wire

[src/jssp_queue.sv]
// Short bundle queue between the parse front end and the result back end.
// Depends on jssp_pkg.
`default_nettype none

module jssp_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire jssp_pkg::t_bundle i_data,
    input  wire logic              i_pop,
    output jssp_pkg::t_bundle      o_head,
    output logic                   o_valid,
    output logic                   o_full
);

    localparam int AW = $clog2(jssp_pkg::Q_DEPTH);
    localparam int CW = $clog2(jssp_pkg::Q_DEPTH + 1);

    jssp_pkg::t_bundle r_slot [jssp_pkg::Q_DEPTH];
    logic [AW-1:0]     r_wptr, r_rptr;
    logic [CW-1:0]     r_count, n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + AW'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + AW'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_data;
        end
    end

    assign o_head  = r_slot[r_rptr];
    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CW'(jssp_pkg::Q_DEPTH));

endmodule

`default_nettype wire

[src/jssp_back.sv]
// Back end: walks through the results of the head bundle, one per
// accepted output request, and retires the bundle. Depends on jssp_pkg.
`default_nettype none

module jssp_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire jssp_pkg::t_bundle i_head,
    input  wire logic              i_head_valid,
    input  wire logic              i_out_ready,
    output logic                   o_pop,
    output logic                   o_valid,
    output logic [2:0]             o_event_res,
    output logic [1:0]             o_role,
    output logic [7:0]             o_out_byte,
    output logic [4:0]             o_depth,
    output logic [3:0]             o_error_code,
    output logic                   o_run_end
);

    logic [1:0]        r_sub;
    jssp_pkg::t_result cur;
    logic              last_res;

    assign cur      = i_head.res[r_sub];
    assign last_res = (({1'b0, r_sub} + 3'd1) == i_head.cnt);

    assign o_valid      = i_head_valid;
    assign o_event_res  = cur.ev;
    assign o_role       = cur.role;
    assign o_out_byte   = cur.data;
    assign o_depth      = cur.depth;
    assign o_error_code = cur.code;
    assign o_run_end    = last_res;
    assign o_pop        = i_head_valid && i_out_ready && last_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub <= 2'd0;
        end else if (i_head_valid && i_out_ready) begin
            r_sub <= last_res ? 2'd0 : r_sub + 2'd1;
        end
    end

endmodule

`default_nettype wire

[src/json_subset_stream_parser.sv]
// Top level of the JSON subset stream parser: front end, bundle queue and
// back end. Depends on jssp_pkg, jssp_front, jssp_queue and jssp_back.
//
// Usage:
//  - Input channel (i_in_valid / o_in_ready): one text byte per request,
//    with i_is_last set on the final byte of a text.
//  - Output channel (o_out_valid / i_out_ready): one result per request;
//    o_run_end marks the last result caused by an input byte. A byte may
//    cause zero to four results.
//  - Results are registered: a byte's results pass through the bundle
//    queue (one register stage) before they are visible on the output.
//  - Throughput: one byte per cycle while each byte causes at most one
//    result; a byte with n results occupies the back end for n requests.
//    Sustained rate: the back end's drain, one result per ready cycle.
//  - The bundle queue holds four bytes' worth of results; o_in_ready drops
//    only when it is full, so a stalled receiver stalls the input after
//    four pending bytes with results. Nothing is dropped.
//  - Reset clears the parser to expect the opening brace and empties the
//    queue. After the last byte of a text the parser returns to that state.
//  - After an error, bytes produce nothing, the last byte included.
`default_nettype none

module json_subset_stream_parser #(
    parameter int MAX_DEPTH = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_is_last,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [2:0]      o_event_res,
    output logic [1:0]      o_role,
    output logic [7:0]      o_out_byte,
    output logic [4:0]      o_depth,
    output logic [3:0]      o_error_code,
    output logic            o_run_end
);

    jssp_pkg::t_bundle front_bundle;
    jssp_pkg::t_bundle head_bundle;
    logic              front_push;
    logic              in_fire;
    logic              q_valid;
    logic              q_full;
    logic              q_pop;

    // Ready depends only on queue occupancy, never on the receiver.
    assign o_in_ready = !q_full;
    assign in_fire    = i_in_valid && o_in_ready;

    jssp_front #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (in_fire),
        .i_byte   (i_in_byte),
        .i_last   (i_is_last),
        .o_bundle (front_bundle),
        .o_push   (front_push)
    );

    // Only bytes that cause results take a slot.
    jssp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_bundle),
        .i_pop   (q_pop),
        .o_head  (head_bundle),
        .o_valid (q_valid),
        .o_full  (q_full)
    );

    jssp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head_bundle),
        .i_head_valid (q_valid),
        .i_out_ready  (i_out_ready),
        .o_pop        (q_pop),
        .o_valid      (o_out_valid),
        .o_event_res  (o_event_res),
        .o_role       (o_role),
        .o_out_byte   (o_out_byte),
        .o_depth      (o_depth),
        .o_error_code (o_error_code),
        .o_run_end    (o_run_end)
    );

    // Error and done are always the final result of their byte.
    a_term_is_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_event_res == jssp_pkg::EV_ERROR ||
                        o_event_res == jssp_pkg::EV_DONE) |-> o_run_end)
        else $error("error/done result not at end of run");

    // A nonzero code appears exactly on error results.
    a_code_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_event_res == jssp_pkg::EV_ERROR) ==
                         (o_error_code != jssp_pkg::ERR_NONE)))
        else $error("error code mismatch with event");

    // Role is only carried by string events.
    a_role_on_string: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_event_res != jssp_pkg::EV_BYTE &&
        o_event_res != jssp_pkg::EV_STR_END |-> o_role == jssp_pkg::ROLE_KEY)
        else $error("role set on non-string result");

endmodule

`default_nettype wire

[verif/tb_json_subset_stream_parser.sv]
// Self-checking testbench for json_subset_stream_parser: a short directed byte script,
// then random generated texts checked against an in-bench parser model.
// Depends on jssp_pkg and the json_subset_stream_parser RTL.

module tb_json_subset_stream_parser;
    import jssp_pkg::*;

    localparam int DEPTH_LIMIT  = 16;
    localparam int RANDOM_ITEMS = 150;     // random bytes, deep text included
    localparam int DRAIN_CYCLES = 20;      // settle time after the last result
    localparam int CYCLE_LIMIT  = 200000;  // watchdog, far above the slowest run

    // Role field is zero for events that carry no string role
    localparam logic [1:0] ROLE_NONE = 2'd0;

    // One output request as the parser should present it
    typedef struct {
        t_event     ev;
        logic [1:0] role;
        logic [7:0] data;
        logic [4:0] depth;
        logic [3:0] code;
        logic       run_end;
    } t_parse_event;

    // Directed script row. When typed is set, the row's single result is
    // written out by hand and replaces the model's output for that byte.
    typedef struct {
        logic [7:0] ch;
        logic       is_end;
        logic       typed;
        t_event     ev;
        logic [4:0] depth;
        logic [3:0] code;
    } t_script_row;

    //------------------------------------------------------------------
    // Clock, reset and DUT
    //------------------------------------------------------------------
    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_in_valid   = 1'b0;
    logic [7:0] i_in_byte    = 8'h00;
    logic       i_is_last    = 1'b0;
    logic       i_out_ready  = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [2:0] o_event_res;
    logic [1:0] o_role;
    logic [7:0] o_out_byte;
    logic [4:0] o_depth;
    logic [3:0] o_error_code;
    logic       o_run_end;

    always #5 i_clk = ~i_clk;

    json_subset_stream_parser #(
        .MAX_DEPTH(DEPTH_LIMIT)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_byte   (i_in_byte),
        .i_is_last   (i_is_last),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_event_res (o_event_res),
        .o_role      (o_role),
        .o_out_byte  (o_out_byte),
        .o_depth     (o_depth),
        .o_error_code(o_error_code),
        .o_run_end   (o_run_end)
    );

    //------------------------------------------------------------------
    // Parser model state. Mirrors the block's mode machine; every
    // accepted byte before an error advances it once.
    //------------------------------------------------------------------
    t_mode       pm_mode     = M_TOP;
    logic [4:0]  pm_depth    = '0;
    logic [1:0]  pm_role     = ROLE_KEY;
    logic [2:0]  pm_hex_cnt  = '0;
    logic [15:0] pm_rune     = '0;
    logic        pm_in_array = 1'b0;
    logic        pm_top_done = 1'b0;
    logic        pm_failed   = 1'b0;

    t_parse_event step_events[$];      // events caused by the current byte
    t_parse_event pending_events[$];   // events the DUT still owes, oldest first

    logic [7:0] text_buf[$];           // random text under construction

    int  fail_count    = 0;
    int  cycle_count   = 0;
    int  ready_hold    = 0;
    bit  send_idle_on  = 1'b1;
    bit  recv_stall_on = 1'b1;

    function automatic void clear_parser();
        pm_mode     = M_TOP;
        pm_depth    = '0;
        pm_role     = ROLE_KEY;
        pm_hex_cnt  = '0;
        pm_rune     = '0;
        pm_in_array = 1'b0;
        pm_top_done = 1'b0;
        pm_failed   = 1'b0;
    endfunction

    // Depth is sampled after the state change, as the block reports it
    function automatic void note(t_event ev, logic [1:0] role, logic [7:0] data,
                                 logic [3:0] code);
        t_parse_event e;
        e = '{ev, role, data, pm_depth, code, 1'b0};
        if (step_events.size() < MAX_RES) step_events.insert(step_events.size(), e);
    endfunction

    function automatic void flag_error(logic [3:0] code);
        pm_failed = 1'b1;
        note(EV_ERROR, ROLE_NONE, 8'h00, code);
    endfunction

    function automatic void shut_object();
        if (pm_depth != 0) pm_depth = pm_depth - 5'd1;
        note(EV_OBJ_CLOSE, ROLE_NONE, 8'h00, ERR_NONE);
        if (pm_depth == 0) begin
            pm_top_done = 1'b1;
            pm_mode     = M_TAIL;
        end else begin
            pm_mode = M_OBJ_NEXT;
        end
    endfunction

    function automatic void shut_array();
        pm_in_array = 1'b0;
        pm_mode     = M_OBJ_NEXT;
        note(EV_ARR_CLOSE, ROLE_NONE, 8'h00, ERR_NONE);
    endfunction

    function automatic void open_string(logic [1:0] role);
        pm_role = role;
        pm_mode = M_STR;
    endfunction

    // UTF-8 encoding of a 16-bit code point; surrogates pass through
    function automatic void put_rune(logic [15:0] r);
        if (r < 16'h0080) begin
            note(EV_BYTE, pm_role, r[7:0], ERR_NONE);
        end else if (r < 16'h0800) begin
            note(EV_BYTE, pm_role, {3'b110, r[10:6]}, ERR_NONE);
            note(EV_BYTE, pm_role, {2'b10, r[5:0]}, ERR_NONE);
        end else begin
            note(EV_BYTE, pm_role, {4'b1110, r[15:12]}, ERR_NONE);
            note(EV_BYTE, pm_role, {2'b10, r[11:6]}, ERR_NONE);
            note(EV_BYTE, pm_role, {2'b10, r[5:0]}, ERR_NONE);
        end
    endfunction

    function automatic void advance_parser(logic [7:0] ch);
        logic       ws;
        logic [3:0] dig;
        ws = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_LF) || (ch == CH_CR);
        case (pm_mode)
            M_TOP: begin
                if (!ws) begin
                    if (ch == CH_LBRACE) begin
                        pm_depth = 5'd1;
                        pm_mode  = M_OBJ_FIRST;
                        note(EV_OBJ_OPEN, ROLE_NONE, 8'h00, ERR_NONE);
                    end else begin
                        flag_error(ERR_BRACE);
                    end
                end
            end
            M_OBJ_FIRST: begin
                if (!ws) begin
                    if (ch == CH_RBRACE) shut_object();
                    else if (ch == CH_QUOTE) open_string(ROLE_KEY);
                    else flag_error(ERR_QUOTE);
                end
            end
            M_OBJ_KEY: begin
                if (!ws) begin
                    if (ch == CH_QUOTE) open_string(ROLE_KEY);
                    else flag_error(ERR_QUOTE);
                end
            end
            M_COLON: begin
                if (!ws) begin
                    if (ch == CH_COLON) pm_mode = M_VALUE;
                    else flag_error(ERR_COLON);
                end
            end
            M_VALUE: begin
                if (!ws) begin
                    if (ch == CH_QUOTE) begin
                        open_string(ROLE_VALUE);
                    end else if (ch == CH_LBRACE) begin
                        if (pm_depth >= DEPTH_LIMIT) begin
                            flag_error(ERR_DEPTH);
                        end else begin
                            pm_depth = pm_depth + 5'd1;
                            pm_mode  = M_OBJ_FIRST;
                            note(EV_OBJ_OPEN, ROLE_NONE, 8'h00, ERR_NONE);
                        end
                    end else if (ch == CH_LBRACK) begin
                        pm_in_array = 1'b1;
                        pm_mode     = M_ARR_FIRST;
                        note(EV_ARR_OPEN, ROLE_NONE, 8'h00, ERR_NONE);
                    end else begin
                        flag_error(ERR_SYNTAX);
                    end
                end
            end
            M_OBJ_NEXT: begin
                if (!ws) begin
                    if (ch == CH_RBRACE) shut_object();
                    else if (ch == CH_COMMA) pm_mode = M_OBJ_KEY;
                    else flag_error(ERR_COMMA_BRC);
                end
            end
            M_ARR_FIRST: begin
                if (!ws) begin
                    if (ch == CH_RBRACK) shut_array();
                    else if (ch == CH_QUOTE) open_string(ROLE_ENTRY);
                    else flag_error(ERR_QUOTE);
                end
            end
            M_ARR_ENTRY: begin
                if (!ws) begin
                    if (ch == CH_QUOTE) open_string(ROLE_ENTRY);
                    else flag_error(ERR_QUOTE);
                end
            end
            M_ARR_NEXT: begin
                if (!ws) begin
                    if (ch == CH_RBRACK) shut_array();
                    else if (ch == CH_COMMA) pm_mode = M_ARR_ENTRY;
                    else flag_error(ERR_COMMA_BRK);
                end
            end
            M_STR: begin
                if (ch == CH_QUOTE) begin
                    note(EV_STR_END, pm_role, 8'h00, ERR_NONE);
                    if (pm_role == ROLE_KEY) pm_mode = M_COLON;
                    else if (pm_role == ROLE_VALUE) pm_mode = M_OBJ_NEXT;
                    else pm_mode = M_ARR_NEXT;
                end else if (ch == CH_BSLASH) begin
                    pm_mode = M_ESC;
                end else begin
                    note(EV_BYTE, pm_role, ch, ERR_NONE);
                end
            end
            M_ESC: begin
                pm_mode = M_STR;
                case (ch)
                    CH_QUOTE, CH_BSLASH, CH_SLASH: note(EV_BYTE, pm_role, ch, ERR_NONE);
                    CH_B: note(EV_BYTE, pm_role, 8'h08, ERR_NONE);
                    CH_F: note(EV_BYTE, pm_role, 8'h0C, ERR_NONE);
                    CH_N: note(EV_BYTE, pm_role, 8'h0A, ERR_NONE);
                    CH_R: note(EV_BYTE, pm_role, 8'h0D, ERR_NONE);
                    CH_T: note(EV_BYTE, pm_role, 8'h09, ERR_NONE);
                    CH_U: begin
                        pm_mode    = M_HEX;
                        pm_hex_cnt = '0;
                        pm_rune    = '0;
                    end
                    default: flag_error(ERR_ESCAPE);
                endcase
            end
            M_HEX: begin
                // letters map through the low nibble: 'A'/'a' is 1, plus 9
                if (ch >= "0" && ch <= "9") begin
                    dig = ch[3:0];
                end else if ((ch >= "A" && ch <= "F") || (ch >= "a" && ch <= "f")) begin
                    dig = ch[3:0] + 4'd9;
                end else begin
                    flag_error(ERR_HEX);
                    return;
                end
                pm_rune    = {pm_rune[11:0], dig};
                pm_hex_cnt = pm_hex_cnt + 3'd1;
                if (pm_hex_cnt >= 3'd4) begin
                    put_rune(pm_rune);
                    pm_hex_cnt = '0;
                    pm_mode    = M_STR;
                end
            end
            M_TAIL: begin
                if (!ws) flag_error(ERR_EXTRA);
            end
            default: flag_error(ERR_SYNTAX);
        endcase
    endfunction

    // Fills step_events with everything one accepted byte causes
    function automatic void decode_text_byte(logic [7:0] ch, logic is_end);
        step_events.delete();
        if (!pm_failed) advance_parser(ch);
        if (is_end) begin
            if (!pm_failed) begin
                if (pm_top_done) note(EV_DONE, ROLE_NONE, 8'h00, ERR_NONE);
                else if (pm_mode == M_STR || pm_mode == M_ESC || pm_mode == M_HEX)
                    flag_error(ERR_UNTERM);
                else flag_error(ERR_EOF);
            end
            clear_parser();
        end
        if (step_events.size() > 0) step_events[step_events.size() - 1].run_end = 1'b1;
    endfunction

    //------------------------------------------------------------------
    // Directed script. Hand-typed results where they are obvious; the
    // rest goes through the model.
    //------------------------------------------------------------------
    t_script_row opening_script [27] = '{
        // top byte all ones, and it is the last byte: wrong opener
        '{8'hFF,      1'b1, 1'b1, EV_ERROR,     5'd0, ERR_BRACE},
        // {"<nul>\uFfFf":[]} then trailing space as last byte
        '{CH_LBRACE,  1'b0, 1'b1, EV_OBJ_OPEN,  5'd1, ERR_NONE},
        '{CH_QUOTE,   1'b0, 1'b0, EV_BYTE,      5'd0, ERR_NONE},
        '{8'h00,      1'b0, 1'b0, EV_BYTE,      5'd0, ERR_NONE},
        '{CH_BSLASH,  1'b0, 1'b0, EV_BYTE,      5'd0, ERR_NONE},
        '{CH_U,       1'b0, 1'b0, EV_BYTE,      5'd0, ERR_NONE},
        '{8'h46,      1'b0, 1'b0, EV_BYTE,      5'd0, ERR_NONE},
        '{CH_F,       1'b0, 1'b0, EV_BYTE,      5'd0, ERR_NONE},
        '{8'h46,      1'b0, 1'b0, EV_BYTE,      5'd0, ERR_NONE},
        '{CH_F,       1'b0, 1'b0, EV_BYTE,      5'd0, ERR_NONE},   // three-byte rune
        '{CH_QUOTE,   1'b0, 1'b0, EV_BYTE,      5'd0, ERR_NONE},
        '{CH_COLON,   1'b0, 1'b0, EV_BYTE,      5'd0, ERR_NONE},
        '{CH_LBRACK,  1'b0, 1'b0, EV_BYTE,      5'd0, ERR_NONE},
        '{CH_RBRACK,  1'b0, 1'b0, EV_BYTE,      5'd0, ERR_NONE},
        '{CH_RBRACE,  1'b0, 1'b1, EV_OBJ_CLOSE, 5'd0, ERR_NONE},
        '{CH_SPACE,   1'b1, 1'b1, EV_DONE,      5'd0, ERR_NONE},
        // {} then garbage after the closed object
        '{CH_LBRACE,  1'b0, 1'b1, EV_OBJ_OPEN,  5'd1, ERR_NONE},
        '{CH_RBRACE,  1'b0, 1'b1, EV_OBJ_CLOSE, 5'd0, ERR_NONE},
        '{CH_RBRACK,  1'b1, 1'b1, EV_ERROR,     5'd0, ERR_EXTRA},
        // {"\q  -> bad escape, then an ignored last byte
        '{CH_LBRACE,  1'b0, 1'b0, EV_BYTE,      5'd0, ERR_NONE},
        '{CH_QUOTE,   1'b0, 1'b0, EV_BYTE,      5'd0, ERR_NONE},
        '{CH_BSLASH,  1'b0, 1'b0, EV_BYTE,      5'd0, ERR_NONE},
        '{8'h71,      1'b0, 1'b1, EV_ERROR,     5'd1, ERR_ESCAPE},
        '{8'h7A,      1'b1, 1'b0, EV_BYTE,      5'd0, ERR_NONE},
        // {" with the text ending inside the string
        '{CH_LBRACE,  1'b0, 1'b1, EV_OBJ_OPEN,  5'd1, ERR_NONE},
        '{CH_QUOTE,   1'b1, 1'b1, EV_ERROR,     5'd1, ERR_UNTERM},
        // lone { as the whole text: open plus premature end
        '{CH_LBRACE,  1'b1, 1'b0, EV_BYTE,      5'd0, ERR_NONE}
    };

    //------------------------------------------------------------------
    // Random text builders, all appending to text_buf
    //------------------------------------------------------------------
    function automatic void add_byte(logic [7:0] c);
        text_buf.insert(text_buf.size(), c);
    endfunction

    function automatic logic [7:0] pick_ws();
        case ($urandom_range(0, 3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_LF;
            default: return CH_CR;
        endcase
    endfunction

    function automatic void put_gap();
        int n;
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
        repeat (n) add_byte(pick_ws());
    endfunction

    // \uXXXX with mixed-case digits; now and then one digit is broken
    function automatic void put_unicode();
        logic [15:0] cp;
        logic [3:0]  nib;
        logic [7:0]  c;
        int          bad;
        case ($urandom_range(0, 2))
            0:       cp = 16'($urandom_range(0, 'h7F));
            1:       cp = 16'($urandom_range('h80, 'h7FF));
            default: cp = 16'($urandom_range('h800, 'hFFFF));
        endcase
        bad = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : -1;
        add_byte(CH_BSLASH);
        add_byte(CH_U);
        for (int k = 3; k >= 0; k--) begin
            nib = cp[4*k +: 4];
            if (nib < 4'd10) c = 8'h30 + {4'h0, nib};
            else c = ($urandom_range(0, 1) ? 8'h37 : 8'h57) + {4'h0, nib};
            if (k == bad) begin
                // just outside each digit range
                case ($urandom_range(0, 4))
                    0:       c = CH_COLON;
                    1:       c = 8'h40;
                    2:       c = 8'h60;
                    3:       c = 8'h67;
                    default: c = CH_SLASH;
                endcase
            end
            add_byte(c);
        end
    endfunction

    function automatic void put_string();
        int         n;
        logic [7:0] c;
        add_byte(CH_QUOTE);
        n = $urandom_range(0, 4);
        repeat (n) begin
            case ($urandom_range(0, 11))
                0: add_byte(8'($urandom_range('h80, 'hFF)));
                1: add_byte(8'($urandom_range('h00, 'h1F)));
                2: begin
                    add_byte(CH_BSLASH);
                    case ($urandom_range(0, 7))
                        0:       add_byte(CH_QUOTE);
                        1:       add_byte(CH_BSLASH);
                        2:       add_byte(CH_SLASH);
                        3:       add_byte(CH_B);
                        4:       add_byte(CH_F);
                        5:       add_byte(CH_N);
                        6:       add_byte(CH_R);
                        default: add_byte(CH_T);
                    endcase
                end
                3, 4: put_unicode();
                5: begin
                    // escape letter outside the accepted set
                    do c = 8'($urandom());
                    while (c inside {CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N,
                                     CH_R, CH_T, CH_U});
                    if ($urandom_range(0, 1) == 0) begin
                        add_byte(CH_BSLASH);
                        add_byte(c);
                    end
                end
                default: begin
                    do c = 8'($urandom_range('h20, 'h7E));
                    while (c == CH_QUOTE || c == CH_BSLASH);
                    add_byte(c);
                end
            endcase
        end
        add_byte(CH_QUOTE);
    endfunction

    function automatic void put_array();
        int n;
        add_byte(CH_LBRACK);
        n = $urandom_range(0, 3);
        for (int k = 0; k < n; k++) begin
            put_gap();
            if (k != 0) begin
                add_byte(CH_COMMA);
                put_gap();
            end
            put_string();
        end
        put_gap();
        add_byte(CH_RBRACK);
    endfunction

    // Well-formed object, nested up to three levels, built without recursion
    function automatic void put_object_text();
        int lvl;
        int budget;
        bit fresh [0:4];
        put_gap();
        add_byte(CH_LBRACE);
        lvl      = 1;
        fresh[1] = 1'b1;
        budget   = $urandom_range(0, 6);
        while (lvl > 0) begin
            put_gap();
            if (budget == 0 || $urandom_range(0, 3) == 0) begin
                add_byte(CH_RBRACE);
                lvl--;
            end else begin
                budget--;
                if (!fresh[lvl]) begin
                    add_byte(CH_COMMA);
                    put_gap();
                end
                fresh[lvl] = 1'b0;
                put_string();
                put_gap();
                add_byte(CH_COLON);
                put_gap();
                case ($urandom_range(0, 3))
                    0: begin
                        if (lvl < 3) begin
                            add_byte(CH_LBRACE);
                            lvl++;
                            fresh[lvl] = 1'b1;
                        end else begin
                            put_string();
                        end
                    end
                    1:       put_array();
                    default: put_string();
                endcase
            end
        end
    endfunction

    // Chain of {"":{ ... reaching the depth limit; the last brace overflows
    function automatic void put_deep_text();
        add_byte(CH_LBRACE);
        repeat (DEPTH_LIMIT) begin
            add_byte(CH_QUOTE);
            add_byte(CH_QUOTE);
            add_byte(CH_COLON);
            add_byte(CH_LBRACE);
        end
    endfunction

    // Damage a clean text (noise, swapped byte, cut, trailing data) or leave it clean
    function automatic void spoil_text();
        int cut;
        case ($urandom_range(0, 9))
            0: begin
                text_buf.delete();
                repeat ($urandom_range(1, 6)) add_byte(8'($urandom()));
            end
            1, 2: text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom());
            3: begin
                if (text_buf.size() > 1) begin
                    cut = $urandom_range(1, text_buf.size() - 1);
                    while (text_buf.size() > cut) void'(text_buf.pop_back());
                end
            end
            4: begin
                put_gap();
                add_byte(8'($urandom()));
            end
            default: begin
                if ($urandom_range(0, 1) == 0) put_gap();
            end
        endcase
    endfunction

    //------------------------------------------------------------------
    // Input side
    //------------------------------------------------------------------
    // Present one byte, hold it until taken, then queue what it causes.
    // Valid is only dropped at the start of an idle burst, so a back-to-back
    // byte never sees a low/high pair of assignments in one step.
    task automatic send_request(t_script_row row);
        t_parse_event e;
        if (send_idle_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= row.ch;
        i_is_last  <= row.is_end;
        do @(posedge i_clk); while (!o_in_ready);
        decode_text_byte(row.ch, row.is_end);
        if (row.typed) begin
            e = '{row.ev, ROLE_NONE, 8'h00, row.depth, row.code, 1'b1};
            pending_events.insert(pending_events.size(), e);
        end else begin
            foreach (step_events[k]) pending_events.insert(pending_events.size(), step_events[k]);
        end
    endtask

    task automatic send_text();
        t_script_row row;
        row = '{8'h00, 1'b0, 1'b0, EV_BYTE, 5'd0, ERR_NONE};
        foreach (text_buf[k]) begin
            row.ch     = text_buf[k];
            row.is_end = (k == text_buf.size() - 1);
            send_request(row);
        end
    endtask

    //------------------------------------------------------------------
    // Output side: checks each taken request and drives ready with
    // random stall bursts.
    //------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_parse_event want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_events.size() == 0) begin
                $error("result with nothing pending: event_res %0d, code %0d",
                       o_event_res, o_error_code);
                fail_count++;
            end else begin
                want = pending_events.pop_front();
                if (o_event_res !== want.ev) begin
                    $error("event_res: expected %0d, got %0d", want.ev, o_event_res);
                    fail_count++;
                end
                if (o_role !== want.role) begin
                    $error("role: expected %0d, got %0d", want.role, o_role);
                    fail_count++;
                end
                if (o_out_byte !== want.data) begin
                    $error("out_byte: expected 0x%02h, got 0x%02h", want.data, o_out_byte);
                    fail_count++;
                end
                if (o_depth !== want.depth) begin
                    $error("depth: expected %0d, got %0d", want.depth, o_depth);
                    fail_count++;
                end
                if (o_error_code !== want.code) begin
                    $error("error_code: expected %0d, got %0d", want.code, o_error_code);
                    fail_count++;
                end
                if (o_run_end !== want.run_end) begin
                    $error("run_end: expected %0d, got %0d", want.run_end, o_run_end);
                    fail_count++;
                end
            end
        end

        // ready_hold counts the low cycles left in a stall burst
        if (ready_hold > 0) begin
            ready_hold  <= ready_hold - 1;
            i_out_ready <= (ready_hold == 1);
        end else if (recv_stall_on && $urandom_range(0, 9) == 0) begin
            ready_hold  <= $urandom_range(1, 18);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    //------------------------------------------------------------------
    // Main sequence
    //------------------------------------------------------------------
    initial begin
        int  random_sent;
        bit  quiet;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (opening_script[k]) send_request(opening_script[k]);

        // one text down to the nesting limit and past it
        text_buf.delete();
        put_deep_text();
        send_text();
        random_sent = text_buf.size();

        while (random_sent < RANDOM_ITEMS) begin
            // last quarter runs with no gaps and no stalls
            quiet         = (random_sent >= RANDOM_ITEMS * 3 / 4);
            send_idle_on  = !quiet && ($urandom_range(0, 3) != 0);
            recv_stall_on = !quiet && ($urandom_range(0, 3) != 0);
            text_buf.delete();
            put_object_text();
            spoil_text();
            send_text();
            random_sent += text_buf.size();
        end
        i_in_valid <= 1'b0;

        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
